// ===== sv/dad_pkg.sv =====
package dad_pkg;

  localparam int unsigned MaxClasses = 128;
  localparam int unsigned CntW       = $clog2(MaxClasses + 1);
  localparam int unsigned LabelW     = 7;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned ScoreW     = 16;
  localparam int unsigned GainW      = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  // twice-center +/- size, signed
  localparam int unsigned TwiceW     = CoordW + 3;
  localparam int unsigned ProdW      = (TwiceW - 1) + GainW;
  localparam int unsigned GainShift  = 13;

  localparam logic [ScoreW-1:0] ThresholdRst = ScoreW'(32768);
  localparam logic [GainW-1:0]  GainRst      = GainW'(4096);
  localparam logic [CoordW-1:0] ImgWidthRst  = CoordW'(10240);
  localparam logic [CoordW-1:0] ImgHeightRst = CoordW'(7680);

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 2'd0,
    CfgGain      = 2'd1,
    CfgImgWidth  = 2'd2,
    CfgImgHeight = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ActBox   = 1'b0,
    ActScore = 1'b1
  } action_e;

  typedef struct packed {
    logic              action;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] box_width;
    logic [CoordW-1:0] box_height;
    logic [ScoreW-1:0] class_score;
    logic              last_class;
  } in_t;

  // Scale a doubled Q12.5 coordinate by a Q4.12 gain back to Q12.4, clamp to [0, bound].
  function automatic logic [CoordW-1:0] corner(input logic signed [TwiceW-1:0] twice,
                                               input logic [GainW-1:0] gain,
                                               input logic [CoordW-1:0] bound);
    logic [ProdW-1:0]           prod;
    logic [ProdW-GainShift-1:0] scaled;
    logic [CoordW-1:0]          res;
    prod   = ProdW'(twice[TwiceW-2:0]) * ProdW'(gain);
    scaled = prod[ProdW-1:GainShift];
    if (twice <= 0) begin
      res = '0;
    end else if (scaled > (ProdW-GainShift)'(bound)) begin
      res = bound;
    end else begin
      res = scaled[CoordW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/dad_in_if.sv =====
interface dad_in_if;
  import dad_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [CoordW-1:0] center_x;
  logic [CoordW-1:0] center_y;
  logic [CoordW-1:0] box_width;
  logic [CoordW-1:0] box_height;
  logic [ScoreW-1:0] class_score;
  logic              last_class;

  modport source (output valid, action, center_x, center_y, box_width, box_height,
                  class_score, last_class, input ready);
  modport sink (input valid, action, center_x, center_y, box_width, box_height,
                class_score, last_class, output ready);
endinterface

// ===== sv/dad_out_if.sv =====
interface dad_out_if;
  import dad_pkg::*;

  logic              valid;
  logic              ready;
  logic [LabelW-1:0] label;
  logic [ScoreW-1:0] best_score;
  logic [CoordW-1:0] left;
  logic [CoordW-1:0] top;
  logic [CoordW-1:0] right;
  logic [CoordW-1:0] bottom;

  modport source (output valid, label, best_score, left, top, right, bottom, input ready);
  modport sink (input valid, label, best_score, left, top, right, bottom, output ready);
endinterface

// ===== sv/dad_cfg_if.sv =====
interface dad_cfg_if;
  import dad_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/detection_anchor_decode_top.sv =====
// Path: the last class score of an anchor passes through the input register and
//   then the result register before its result is valid.
// Throughput: one item per cycle; the input stage stalls only while a finished
//   result is held because the sink is not ready.
// Reset: asynchronous, active low; the anchor store clears to zero and the
//   registers return to threshold 0.5, gain 1.0, bounds 640 x 480.
module detection_anchor_decode_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  dad_in_if.sink    in_i,
  dad_out_if.source out_o,
  dad_cfg_if.sink   cfg_i
);
  import dad_pkg::*;

  // configuration
  logic [ScoreW-1:0] thr_q;
  logic [GainW-1:0]  gain_q;
  logic [CoordW-1:0] img_w_q, img_h_q;

  // input register
  logic s0_valid_q;
  in_t  s0_q;

  // anchor store
  logic [CoordW-1:0] cx_q, cy_q, bw_q, bh_q;
  logic [ScoreW-1:0] best_q;
  logic [LabelW-1:0] label_q;
  logic [CntW-1:0]   cnt_q;

  // result register
  logic              out_valid_q;
  logic [LabelW-1:0] out_label_q;
  logic [ScoreW-1:0] out_score_q;
  logic [CoordW-1:0] out_left_q, out_top_q, out_right_q, out_bottom_q;

  logic              take, upd, is_score, is_last, emit, adv, in_fire;
  logic [ScoreW-1:0] best_d;
  logic [LabelW-1:0] label_d;
  logic [CntW-1:0]   cnt_d;
  logic signed [TwiceW-1:0] tw_l, tw_t, tw_r, tw_b;
  logic [CoordW-1:0] left_d, top_d, right_d, bottom_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThresholdRst;
      gain_q  <= GainRst;
      img_w_q <= ImgWidthRst;
      img_h_q <= ImgHeightRst;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgThreshold: thr_q   <= cfg_i.data;
        CfgGain:      gain_q  <= cfg_i.data;
        CfgImgWidth:  img_w_q <= cfg_i.data;
        CfgImgHeight: img_h_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // running arg-max; ties keep the earlier class
  always_comb begin
    is_score = (action_e'(s0_q.action) == ActScore);
    is_last  = is_score && s0_q.last_class;
    take     = cnt_q < CntW'(MaxClasses);
    upd      = take && ((cnt_q == '0) || (s0_q.class_score > best_q));
    best_d   = upd ? s0_q.class_score : best_q;
    label_d  = upd ? LabelW'(cnt_q) : label_q;
    cnt_d    = take ? cnt_q + CntW'(1) : cnt_q;
    emit     = s0_valid_q && is_last && (best_d > thr_q);
  end

  always_comb begin
    tw_l = $signed({2'b00, cx_q, 1'b0}) - $signed({3'b000, bw_q});
    tw_r = $signed({2'b00, cx_q, 1'b0}) + $signed({3'b000, bw_q});
    tw_t = $signed({2'b00, cy_q, 1'b0}) - $signed({3'b000, bh_q});
    tw_b = $signed({2'b00, cy_q, 1'b0}) + $signed({3'b000, bh_q});
    left_d   = corner(tw_l, gain_q, img_w_q);
    right_d  = corner(tw_r, gain_q, img_w_q);
    top_d    = corner(tw_t, gain_q, img_h_q);
    bottom_d = corner(tw_b, gain_q, img_h_q);
  end

  // hold the input stage only when its result has nowhere to go
  assign adv        = s0_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !s0_valid_q || adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s0_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_q.action      <= in_i.action;
      s0_q.center_x    <= in_i.center_x;
      s0_q.center_y    <= in_i.center_y;
      s0_q.box_width   <= in_i.box_width;
      s0_q.box_height  <= in_i.box_height;
      s0_q.class_score <= in_i.class_score;
      s0_q.last_class  <= in_i.last_class;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q    <= '0;
      cy_q    <= '0;
      bw_q    <= '0;
      bh_q    <= '0;
      best_q  <= '0;
      label_q <= '0;
      cnt_q   <= '0;
    end else if (adv) begin
      if (!is_score) begin
        cx_q    <= s0_q.center_x;
        cy_q    <= s0_q.center_y;
        bw_q    <= s0_q.box_width;
        bh_q    <= s0_q.box_height;
        best_q  <= '0;
        label_q <= '0;
        cnt_q   <= '0;
      end else if (is_last) begin
        // anchor done: drop the whole store
        cx_q    <= '0;
        cy_q    <= '0;
        bw_q    <= '0;
        bh_q    <= '0;
        best_q  <= '0;
        label_q <= '0;
        cnt_q   <= '0;
      end else begin
        best_q  <= best_d;
        label_q <= label_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_label_q  <= label_d;
      out_score_q  <= best_d;
      out_left_q   <= left_d;
      out_top_q    <= top_d;
      out_right_q  <= right_d;
      out_bottom_q <= bottom_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.label      = out_label_q;
  assign out_o.best_score = out_score_q;
  assign out_o.left       = out_left_q;
  assign out_o.top        = out_top_q;
  assign out_o.right      = out_right_q;
  assign out_o.bottom     = out_bottom_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxClasses))
    else $error("class count past limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && is_last |=> (cnt_q == '0) && (best_q == '0) && (cx_q == '0) && (bw_q == '0))
    else $error("store not cleared after last class");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && emit |=> out_valid_q && (out_score_q > $past(thr_q)))
    else $error("result not loaded or below threshold");

  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_left_q <= out_right_q) && (out_top_q <= out_bottom_q))
    else $error("corners out of order");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_valid_q && !adv |-> emit && out_valid_q && !out_o.ready)
    else $error("input stage held without a blocked result");

endmodule

// ===== bench/detection_anchor_decode_top_test.sv =====
module detection_anchor_decode_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dad_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [LabelW-1:0] label;
    logic [ScoreW-1:0] score;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
  } det_t;

  typedef struct {
    in_t  item;
    bit   typed;
    bit   fires;
    det_t det;
  } row_t;

  typedef struct packed {
    logic [ScoreW-1:0]   thr;
    logic [GainW-1:0]    gain;
    logic [CoordW-1:0]   width;
    logic [CoordW-1:0]   height;
  } regset_t;

  localparam int unsigned GapMax      = 17;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 180;
  localparam int unsigned QShift      = 13;
  localparam int unsigned NumPhases   = 7;

  logic clk_i;
  logic rst_ni;

  dad_in_if  in_if ();
  dad_out_if out_if ();
  dad_cfg_if cfg_if ();

  detection_anchor_decode_top DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Register copies and anchor store of the decoder model
  logic [ScoreW-1:0] thr_q;
  logic [GainW-1:0]  gain_q;
  logic [CoordW-1:0] width_q;
  logic [CoordW-1:0] height_q;
  logic [CoordW-1:0] held_cx, held_cy, held_w, held_h;
  logic [ScoreW-1:0] best_so_far;
  logic [LabelW-1:0] best_class;
  int unsigned       classes_seen;

  det_t        detections_due[$];
  int unsigned mismatches;
  int unsigned items_sent;
  bit          src_calm;
  bit          sink_calm;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void clear_anchor();
    held_cx      = '0;
    held_cy      = '0;
    held_w       = '0;
    held_h       = '0;
    best_so_far  = '0;
    best_class   = '0;
    classes_seen = 0;
  endfunction

  function automatic logic [CoordW-1:0] scaled_corner(input longint twice,
                                                      input logic [CoordW-1:0] bound);
    u64_t v;
    if (twice <= 0) return '0;
    v = (u64_t'(twice) * u64_t'(gain_q)) >> QShift;
    if (v > u64_t'(bound)) return bound;
    return v[CoordW-1:0];
  endfunction

  // Advance the anchor store by one transaction; return 1 when a detection comes out.
  function automatic bit decode_item(input in_t it, output det_t det);
    det = '0;
    if (it.action == ActBox) begin
      held_cx      = it.center_x;
      held_cy      = it.center_y;
      held_w       = it.box_width;
      held_h       = it.box_height;
      best_so_far  = '0;
      best_class   = '0;
      classes_seen = 0;
      return 1'b0;
    end
    if (classes_seen < MaxClasses) begin
      if (classes_seen == 0 || it.class_score > best_so_far) begin
        best_so_far = it.class_score;
        best_class  = LabelW'(classes_seen);
      end
      classes_seen++;
    end
    if (!it.last_class) return 1'b0;
    if (best_so_far <= thr_q) begin
      clear_anchor();
      return 1'b0;
    end
    det.label  = best_class;
    det.score  = best_so_far;
    det.left   = scaled_corner(2 * longint'(held_cx) - longint'(held_w), width_q);
    det.top    = scaled_corner(2 * longint'(held_cy) - longint'(held_h), height_q);
    det.right  = scaled_corner(2 * longint'(held_cx) + longint'(held_w), width_q);
    det.bottom = scaled_corner(2 * longint'(held_cy) + longint'(held_h), height_q);
    clear_anchor();
    return 1'b1;
  endfunction

  function automatic in_t box_item(input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy,
                                   input logic [CoordW-1:0] w, input logic [CoordW-1:0] h,
                                   input logic last);
    in_t it;
    it            = '0;
    it.action     = ActBox;
    it.center_x   = cx;
    it.center_y   = cy;
    it.box_width  = w;
    it.box_height = h;
    it.last_class = last;
    return it;
  endfunction

  function automatic in_t score_item(input logic [ScoreW-1:0] s, input logic last);
    in_t it;
    it             = '0;
    it.action      = ActScore;
    it.class_score = s;
    it.last_class  = last;
    return it;
  endfunction

  function automatic in_t rand_item();
    logic [95:0] r;
    r = {$urandom(), $urandom(), $urandom()};
    return r[$bits(in_t)-1:0];
  endfunction

  // Mostly coordinates inside a typical image so corners are not all clamped
  function automatic logic [CoordW-1:0] rand_coord();
    if ($urandom_range(0, 3) != 0) return CoordW'($urandom_range(0, 12000));
    return CoordW'($urandom());
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(input in_t it, input bit typed = 1'b0,
                           input bit typed_fires = 1'b0, input det_t typed_det = '0);
    int unsigned gap;
    bit          fires;
    det_t        det;
    if ($urandom_range(0, 99) == 0) src_calm = !src_calm;
    gap = src_calm ? 0 : $urandom_range(0, GapMax);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= it.action;
    in_if.center_x    <= it.center_x;
    in_if.center_y    <= it.center_y;
    in_if.box_width   <= it.box_width;
    in_if.box_height  <= it.box_height;
    in_if.class_score <= it.class_score;
    in_if.last_class  <= it.last_class;
    do @(posedge clk_i); while (!in_if.ready);
    fires = decode_item(it, det);
    if (typed) begin
      fires = typed_fires;
      det   = typed_det;
    end
    if (fires) detections_due = {detections_due, det};
    items_sent++;
  endtask

  // Hold off until every detection is out and the pipeline has emptied
  task automatic settle();
    in_if.valid <= 1'b0;
    while (detections_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(input regset_t rs);
    logic [CfgDataW-1:0] vals[4];
    cfg_idx_e            idx;
    vals = '{rs.thr, rs.gain, rs.width, rs.height};
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      case (idx)
        CfgThreshold: thr_q    = vals[i];
        CfgGain:      gain_q   = vals[i];
        CfgImgWidth:  width_q  = vals[i];
        CfgImgHeight: height_q = vals[i];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  // One anchor: mostly a box plus its class scores, with some noise and broken anchors
  task automatic send_anchor();
    int unsigned       kind;
    int unsigned       n_scores;
    logic [ScoreW-1:0] prev;
    in_t               it;
    kind     = $urandom_range(0, 99);
    n_scores = ($urandom_range(0, 39) == 0) ? $urandom_range(126, 132)
                                            : $urandom_range(1, 10);
    prev     = '0;
    if (kind < 6) begin
      send_item(rand_item());
      return;
    end
    if (kind >= 12) begin
      it            = rand_item();
      it.action     = ActBox;
      it.center_x   = rand_coord();
      it.center_y   = rand_coord();
      it.box_width  = rand_coord();
      it.box_height = rand_coord();
      send_item(it);
    end
    for (int i = 0; i < n_scores; i++) begin
      it        = rand_item();
      it.action = ActScore;
      if ($urandom_range(0, 4) == 0) it.class_score = prev;
      prev = it.class_score;
      // truncated anchors never close; the next box restarts them
      it.last_class = (kind < 12 || kind >= 20) && (i == n_scores - 1);
      send_item(it);
    end
  endtask

  always @(posedge clk_i) begin
    det_t want;
    if (out_if.valid && out_if.ready) begin
      if (detections_due.size() == 0) begin
        $error("unexpected detection: label %0d score %0d", out_if.label, out_if.best_score);
        mismatches++;
      end else begin
        want = detections_due.pop_front();
        check_field("label", want.label, out_if.label);
        check_field("best_score", want.score, out_if.best_score);
        check_field("left", want.left, out_if.left);
        check_field("top", want.top, out_if.top);
        check_field("right", want.right, out_if.right);
        check_field("bottom", want.bottom, out_if.bottom);
      end
    end
  end

  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 99) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, GapMax);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  initial begin
    row_t        rows[];
    regset_t     reg_plan[NumPhases];
    int unsigned phase_end;

    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.action      <= ActBox;
    in_if.center_x    <= '0;
    in_if.center_y    <= '0;
    in_if.box_width   <= '0;
    in_if.box_height  <= '0;
    in_if.class_score <= '0;
    in_if.last_class  <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CfgThreshold;
    cfg_if.data       <= '0;
    mismatches = 0;
    items_sent = 0;
    src_calm   = 1'b0;
    sink_calm  = 1'b0;
    thr_q      = ThresholdRst;
    gain_q     = GainRst;
    width_q    = ImgWidthRst;
    height_q   = ImgHeightRst;
    clear_anchor();

    rows = '{
      // score with no box after reset: corners from the zero box
      '{score_item(16'd40000, 1'b1), 1'b1, 1'b1, '{7'd0, 16'd40000, 16'd0, 16'd0, 16'd0, 16'd0}},
      '{box_item(16'd1600, 16'd1600, 16'd320, 16'd320, 1'b0), 1'b1, 1'b0, '0},
      '{score_item(16'd100, 1'b0), 1'b1, 1'b0, '0},
      '{score_item(16'd50000, 1'b0), 1'b1, 1'b0, '0},
      // tie keeps class 1
      '{score_item(16'd50000, 1'b0), 1'b1, 1'b0, '0},
      '{score_item(16'd20000, 1'b1), 1'b1, 1'b1,
        '{7'd1, 16'd50000, 16'd1440, 16'd1440, 16'd1760, 16'd1760}},
      // box with last_class set still loads
      '{box_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1), 1'b1, 1'b0, '0},
      '{score_item(16'hffff, 1'b1), 1'b1, 1'b1,
        '{7'd0, 16'hffff, 16'd10240, 16'd7680, 16'd10240, 16'd7680}},
      // best equal to threshold is dropped
      '{box_item(16'd0, 16'd0, 16'd100, 16'd200, 1'b0), 1'b1, 1'b0, '0},
      '{score_item(16'd32768, 1'b1), 1'b1, 1'b0, '0},
      // new box in mid-anchor restarts the arg-max
      '{box_item(16'd5000, 16'd3000, 16'd1000, 16'd600, 1'b0), 1'b1, 1'b0, '0},
      '{score_item(16'd60000, 1'b0), 1'b1, 1'b0, '0},
      '{box_item(16'd0, 16'd0, 16'd100, 16'd200, 1'b0), 1'b1, 1'b0, '0},
      '{score_item(16'd40000, 1'b1), 1'b1, 1'b1,
        '{7'd0, 16'd40000, 16'd0, 16'd0, 16'd50, 16'd100}},
      '{score_item(16'd32769, 1'b1), 1'b1, 1'b1, '{7'd0, 16'd32769, 16'd0, 16'd0, 16'd0, 16'd0}},
      '{score_item(16'd0, 1'b0), 1'b1, 1'b0, '0},
      '{score_item(16'd0, 1'b1), 1'b1, 1'b0, '0},
      '{box_item(16'h8000, 16'h4000, 16'h0001, 16'h7fff, 1'b0), 1'b0, 1'b0, '0},
      '{score_item(16'h0001, 1'b0), 1'b0, 1'b0, '0},
      '{score_item(16'hfffe, 1'b0), 1'b0, 1'b0, '0},
      '{score_item(16'hfffe, 1'b1), 1'b0, 1'b0, '0},
      '{box_item(16'd12345, 16'd6789, 16'd23456, 16'd3456, 1'b1), 1'b0, 1'b0, '0},
      '{score_item(16'd45678, 1'b1), 1'b0, 1'b0, '0}
    };

    reg_plan[0] = '{ThresholdRst, GainRst, ImgWidthRst, ImgHeightRst};
    reg_plan[1] = '{16'd0, 16'hffff, 16'hffff, 16'hffff};
    reg_plan[2] = '{16'hffff, 16'd0, 16'd0, 16'd0};
    reg_plan[3] = '{16'd1, 16'd8192, 16'd5000, 16'd3000};
    reg_plan[4] = '{ScoreW'($urandom()), GainW'($urandom()), CoordW'($urandom()),
                    CoordW'($urandom())};
    reg_plan[5] = '{ScoreW'($urandom()), GainW'($urandom_range(0, 16384)),
                    CoordW'($urandom_range(0, 12000)), CoordW'($urandom_range(0, 12000))};
    reg_plan[6] = '{16'd20000, 16'd1, 16'd1, 16'hffff};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].fires, rows[i].det);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_regs(reg_plan[p]);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) send_anchor();
    end

    settle();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
